// ===== rtl/lifua_pkg.sv =====
package lifua_pkg;

    // unit pool size and derived widths
    localparam int MAX_UNITS  = 16;
    localparam int UNIT_IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int UNIT_NUM_W = 5;
    localparam int TIME_W     = 32;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNITS_IN_USE = 3'h0;

    // request and result payloads
    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] duration;
    } req_t;

    typedef struct packed {
        logic                  granted;
        logic [UNIT_NUM_W-1:0] unit_number;
    } res_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic compare;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

// ===== rtl/lowest_index_free_unit_allocator_unit.sv =====
// channel  | direction | handshake         | payload
// ---------+-----------+-------------------+-------------------------------
// s_       | in        | s_valid / s_ready | req_t: arrival_time, duration
// m_       | out       | m_valid / m_ready | res_t: granted, unit_number
// apb      | in        | psel / penable    | units_in_use at byte address 0
//
// one request at a time: capture, a compare of all units, then the
// lowest-index pick and busy-until write, set by the controller sequence
// a result may wait in the output register while the next request is taken
// an upd step stalls only while the output register is still full
// synchronous active-low reset: all units free, units_in_use = 16
module lowest_index_free_unit_allocator_unit
    import lifua_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_payload,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [UNIT_NUM_W-1:0] units_reg;
    logic                  units_sel;
    dp_cmd_t               cmd;
    dp_status_t            status;

    // configuration register
    assign pready    = 1'b1;
    assign units_sel = (paddr[CFG_ADDR_W-1:2] == ADDR_UNITS_IN_USE[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            units_reg <= UNIT_NUM_W'(MAX_UNITS);
        end else if (psel && penable && pwrite && pready && units_sel) begin
            units_reg <= pwdata[UNIT_NUM_W-1:0];
        end
    end

    assign prdata = units_sel ? CFG_DATA_W'(units_reg) : '0;

    // controller
    lifua_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    lifua_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_payload    (s_payload),
        .units_in_use (units_reg),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_payload    (m_payload)
    );

`ifndef SYNTHESIS
    // a grant names a real, enabled unit
    a_grant_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.granted) |->
            (m_payload.unit_number != '0) && (m_payload.unit_number <= units_reg))
        else $error("grant to a unit outside the enabled range");

    // a dropped request reports unit zero
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.granted) |-> (m_payload.unit_number == '0))
        else $error("dropped request with non-zero unit number");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in flight");

    // a new result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("pending result overwritten or lost");
`endif

endmodule

// ===== rtl/lifua_ctrl.sv =====
module lifua_ctrl
    import lifua_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load_req = 1'b0;
        cmd.compare  = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                // wait until the output register is free or being emptied
                if (!status.out_full || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lifua_dp.sv =====
module lifua_dp
    import lifua_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  req_t                  s_payload,
    input  logic [UNIT_NUM_W-1:0] units_in_use,
    input  logic                  m_ready,
    output logic                  m_valid,
    output res_t                  m_payload
);

    req_t                  req_reg;
    logic [MAX_UNITS-1:0]  hit_reg;
    logic [TIME_W-1:0]     end_reg;
    logic [TIME_W-1:0]     busy_reg [MAX_UNITS];
    logic                  out_valid_reg;
    res_t                  out_reg;

    logic [MAX_UNITS-1:0]  hit_next;
    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     end_next;
    logic                  any_hit;
    logic [UNIT_IDX_W-1:0] pick_idx;
    res_t                  res_next;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_payload;
        end
    end

    // free and enabled compare per unit, saturating end time
    always_comb begin
        for (int k = 0; k < MAX_UNITS; k++) begin
            hit_next[k] = (UNIT_NUM_W'(k) < units_in_use) &&
                          (busy_reg[k] <= req_reg.arrival_time);
        end
        sum      = {1'b0, req_reg.arrival_time} + {1'b0, req_reg.duration};
        end_next = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            hit_reg <= hit_next;
            end_reg <= end_next;
        end
    end

    // lowest index wins
    always_comb begin
        any_hit  = |hit_reg;
        pick_idx = '0;
        for (int k = MAX_UNITS - 1; k >= 0; k--) begin
            if (hit_reg[k]) begin
                pick_idx = UNIT_IDX_W'(k);
            end
        end
        res_next.granted     = any_hit;
        res_next.unit_number = any_hit ?
                               (UNIT_NUM_W'(pick_idx) + UNIT_NUM_W'(1)) : '0;
    end

    // busy-until table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_UNITS; k++) begin
                busy_reg[k] <= '0;
            end
        end else if (cmd.commit && any_hit) begin
            busy_reg[pick_idx] <= end_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= res_next;
        end
    end

    assign status.out_full = out_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_payload       = out_reg;

endmodule
